// ===== rtl/signed_128bit_alu_assert.svh =====
// Assertion macros for the signed 128-bit ALU.
// Included by the top level; no other dependencies.
`ifndef SIGNED_128BIT_ALU_ASSERT_SVH
`define SIGNED_128BIT_ALU_ASSERT_SVH
// implication checked at every clock edge, disabled in reset
`define ALU_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ALU_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/s128a_pkg.sv =====
// Package for the signed 128-bit ALU: widths, operation codes, FSM state type.
// No dependencies.
package s128a_pkg;
  localparam int WORD_BITS = 128;
  localparam int HALF_BITS = 64;
  localparam int CNT_BITS  = $clog2(WORD_BITS + 1);
  localparam int SH_BITS   = 7;

  typedef enum logic [3:0] {
    FN_ADD = 4'd0, FN_SUB = 4'd1, FN_MUL = 4'd2, FN_DIV = 4'd3,
    FN_AND = 4'd4, FN_OR = 4'd5, FN_XOR = 4'd6, FN_NOT = 4'd7,
    FN_SAR = 4'd8, FN_SHL = 4'd9, FN_ROL = 4'd10, FN_ROR = 4'd11,
    FN_CMP = 4'd12
  } func_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIX, ST_DONE} state_t;

  // sequencer to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic fix;
  } ctl_t;
endpackage

// ===== rtl/signed_128bit_alu.sv =====
// Signed 128-bit ALU. out_tvalid rises in the cycle after the input
// transaction for add, sub, logic, not, compare and unused codes; for mul, div
// and the shifts and rotates it rises after one load step, 128 one-bit steps
// of the shared datapath and one sign-fix step. in_tready is high only while
// the block is idle, so a new transaction is taken only after the last result
// has been taken. The result holds on out_tdata until taken. Compare flags are
// given for every op.
// Depends on s128a_pkg, s128a_seq, s128a_core and the assert header.
module signed_128bit_alu (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // func[3:0], a_high[67:4], a_low[131:68], b_high[195:132], b_low[259:196],
  // shift_amount[266:260], zero pad
  input  logic [271:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_high[63:0], result_low[127:64], is_greater[128], is_less[129],
  // is_equal[130], divide_error[131], zero pad
  output logic [135:0] out_tdata
);
  import s128a_pkg::*;
  `include "signed_128bit_alu_assert.svh"

  logic [3:0]           func, func_r;
  logic [WORD_BITS-1:0] a, b, res;
  logic [SH_BITS-1:0]   sh;
  ctl_t                 ctl;
  logic [CNT_BITS-1:0]  cnt;
  logic                 idle, done, start, iterate, derr;
  logic                 gt_r, lt_r, eq_r, gt_nxt, lt_nxt, eq_nxt;

  assign func = in_tdata[3:0];
  assign a  = {in_tdata[67:4], in_tdata[131:68]};
  assign b  = {in_tdata[195:132], in_tdata[259:196]};
  assign sh = in_tdata[266:260];
  assign start = in_tvalid && in_tready;
  assign iterate = (func == FN_MUL) || (func == FN_DIV) || (func == FN_SAR) ||
                   (func == FN_SHL) || (func == FN_ROL) || (func == FN_ROR);

  assign gt_nxt = $signed(a) > $signed(b);
  assign lt_nxt = $signed(a) < $signed(b);
  assign eq_nxt = a == b;

  always_ff @(posedge clk) begin
    if (start) begin
      func_r <= func;
      gt_r <= gt_nxt;
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
  end

  s128a_seq u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .iterate(iterate),
    .take(out_tready), .ctl(ctl), .cnt(cnt), .idle(idle), .done(done)
  );

  // shift amount latched at the input transaction
  logic [SH_BITS-1:0] sh_r;
  always_ff @(posedge clk) if (start) sh_r <= sh;

  s128a_core u_core (
    .clk(clk), .ctl(ctl), .func(ctl.load ? func : func_r), .a(a), .b(b),
    .shamt(sh_r), .cnt(cnt), .result(res), .div_err(derr)
  );

  assign in_tready  = idle;
  assign out_tvalid = done;
  assign out_tdata  = {4'b0, derr && (func_r == FN_DIV), eq_r, lt_r, gt_r,
                       res[HALF_BITS-1:0], res[WORD_BITS-1:HALF_BITS]};

  `ALU_ASSERT_IMP(a_ready_excl, clk, rst_n, in_tready, !out_tvalid, "ready while result pending")
  `ALU_ASSERT_IMP(a_flag_one, clk, rst_n, out_tvalid, !(out_tdata[128] && out_tdata[129]), "gt and lt both set")
  `ALU_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped")
endmodule

// ===== rtl/s128a_core.sv =====
// Shared iterative datapath of the signed 128-bit ALU: one adder and
// one-bit shift steps for multiply, divide and the bit-serial shifts.
// Depends on s128a_pkg.
module s128a_core (
  input  logic                             clk,
  input  s128a_pkg::ctl_t                  ctl,
  input  logic [3:0]                       func,
  input  logic [s128a_pkg::WORD_BITS-1:0]  a,
  input  logic [s128a_pkg::WORD_BITS-1:0]  b,
  input  logic [s128a_pkg::SH_BITS-1:0]    shamt,
  input  logic [s128a_pkg::CNT_BITS-1:0]   cnt,
  output logic [s128a_pkg::WORD_BITS-1:0]  result,
  output logic                             div_err
);
  import s128a_pkg::*;
  localparam int W = WORD_BITS;

  logic [W-1:0] acc_r, acc_nxt;  // product, quotient or shift word
  logic [W-1:0] op_r, op_nxt;    // multiplicand / divisor magnitude
  logic [W-1:0] rem_r, rem_nxt;  // multiplier bits / remainder
  logic [W-1:0] num_r, num_nxt;  // dividend magnitude
  logic         neg_r, neg_nxt;
  logic         err_r, err_nxt;
  logic [W:0]   sum;
  logic [W-1:0] add_x, add_y;
  logic         add_c;
  logic [W-1:0] rsh;
  logic         take;

  assign sum = {1'b0, add_x} + {1'b0, add_y} + {{W{1'b0}}, add_c};

  always_comb begin
    add_x = acc_r;
    add_y = op_r;
    add_c = 1'b0;
    rsh   = {rem_r[W-2:0], num_r[W-1]};
    if (ctl.load) begin
      add_x = '0;
      add_y = ~b;
      add_c = 1'b1;
      if (func == FN_ADD) begin
        add_x = a; add_y = b; add_c = 1'b0;
      end else if (func == FN_SUB) begin
        add_x = a;
      end
    end else if (func == FN_DIV && ctl.step) begin
      add_x = rsh; add_y = ~op_r; add_c = 1'b1;
    end else if (ctl.fix) begin
      add_x = '0; add_y = ~acc_r; add_c = 1'b1;
    end
  end

  assign take = sum[W];

  always_comb begin
    acc_nxt = acc_r;
    op_nxt  = op_r;
    rem_nxt = rem_r;
    num_nxt = num_r;
    neg_nxt = neg_r;
    err_nxt = err_r;
    if (ctl.load) begin
      err_nxt = 1'b0;
      neg_nxt = 1'b0;
      acc_nxt = '0;
      op_nxt  = a;
      rem_nxt = b;
      num_nxt = a;
      case (func)
        FN_ADD, FN_SUB: acc_nxt = sum[W-1:0];
        FN_DIV: begin
          err_nxt = (b == '0);
          neg_nxt = a[W-1] ^ b[W-1];
          op_nxt  = b[W-1] ? sum[W-1:0] : b;
          num_nxt = a[W-1] ? (~a + {{(W-1){1'b0}}, 1'b1}) : a;
          rem_nxt = '0;
        end
        FN_AND: acc_nxt = a & b;
        FN_OR:  acc_nxt = a | b;
        FN_XOR: acc_nxt = a ^ b;
        FN_NOT: acc_nxt = ~a;
        FN_SAR, FN_SHL, FN_ROL, FN_ROR: acc_nxt = a;
        default: acc_nxt = '0;
      endcase
    end else if (ctl.step) begin
      case (func)
        FN_MUL: begin
          if (rem_r[0]) acc_nxt = sum[W-1:0];
          op_nxt  = {op_r[W-2:0], 1'b0};
          rem_nxt = {1'b0, rem_r[W-1:1]};
        end
        FN_DIV: begin
          num_nxt = {num_r[W-2:0], 1'b0};
          rem_nxt = take ? sum[W-1:0] : rsh;
          acc_nxt = {acc_r[W-2:0], take};
        end
        FN_SAR: if (cnt < CNT_BITS'(shamt)) acc_nxt = {acc_r[W-1], acc_r[W-1:1]};
        FN_SHL: if (cnt < CNT_BITS'(shamt)) acc_nxt = {acc_r[W-2:0], 1'b0};
        FN_ROL: if (cnt < CNT_BITS'(shamt)) acc_nxt = {acc_r[W-2:0], acc_r[W-1]};
        FN_ROR: if (cnt < CNT_BITS'(shamt)) acc_nxt = {acc_r[0], acc_r[W-1:1]};
        default: acc_nxt = acc_r;
      endcase
    end else if (ctl.fix) begin
      if (err_r) acc_nxt = '0;
      else if (neg_r) acc_nxt = sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    op_r  <= op_nxt;
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    neg_r <= neg_nxt;
    err_r <= err_nxt;
  end

  assign result  = acc_r;
  assign div_err = err_r;
endmodule

// ===== rtl/s128a_seq.sv =====
// Sequencer of the signed 128-bit ALU: load, bit steps, sign fix, hold.
// Depends on s128a_pkg.
module s128a_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           iterate,
  input  logic                           take,
  output s128a_pkg::ctl_t                ctl,
  output logic [s128a_pkg::CNT_BITS-1:0] cnt,
  output logic                           idle,
  output logic                           done
);
  import s128a_pkg::*;

  state_t               state_r, state_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: if (start) begin
        cnt_nxt   = '0;
        state_nxt = iterate ? ST_RUN : ST_DONE;
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(WORD_BITS - 1)) state_nxt = ST_FIX;
      end
      ST_FIX: state_nxt = ST_DONE;
      ST_DONE: if (take) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    idle = 1'b0;
    done = 1'b0;
    case (state_r)
      ST_IDLE: begin idle = 1'b1; ctl.load = start; end
      ST_RUN:  ctl.step = 1'b1;
      ST_FIX:  ctl.fix = 1'b1;
      ST_DONE: done = 1'b1;
      default: idle = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign cnt = cnt_r;
endmodule
